### hw/rtl/vss_pkg.sv
// Package: shared types, constants and helpers of the vector similarity score core.
package vss_pkg;

    localparam int ACC_W   = 48;
    localparam int ELEM_W  = 16;
    localparam int PROD_W  = 34;
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = 2;
    localparam int QLVL_W  = 3;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    // Metric codes; the unused code behaves as cosine
    localparam logic [1:0] MODE_COS = 2'd0;
    localparam logic [1:0] MODE_EUC = 2'd1;
    localparam logic [1:0] MODE_IP  = 2'd2;
    localparam logic [1:0] MODE_RSV = 2'd3;

    typedef struct packed {
        logic signed [ELEM_W-1:0] elem_a;
        logic signed [ELEM_W-1:0] elem_b;
        logic                     last_elem;
    } in_item_t;

    typedef struct packed {
        logic signed [ACC_W-1:0] score;
        logic                    zero_norm;
    } out_item_t;

    // Finished sums of one vector pair
    typedef struct packed {
        logic signed [ACC_W-1:0] dot;
        logic signed [ACC_W-1:0] norm_a;
        logic signed [ACC_W-1:0] norm_b;
        logic signed [ACC_W-1:0] diff_sq;
    } job_t;

    // Saturating add of a sign-extended product into a 48-bit sum
    function automatic logic signed [ACC_W-1:0] sat_add(
        input logic signed [ACC_W-1:0]  acc,
        input logic signed [PROD_W-1:0] p
    );
        logic signed [ACC_W:0] s;
        s = {acc[ACC_W-1], acc} + {{(ACC_W+1-PROD_W){p[PROD_W-1]}}, p};
        if (s[ACC_W] != s[ACC_W-1])
            return s[ACC_W] ? ACC_MIN : ACC_MAX;
        return s[ACC_W-1:0];
    endfunction

endpackage

### hw/rtl/vss_front.sv
// Front end: takes element pairs, forms products and accumulates the four sums.
module vss_front
    import vss_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  in_item_t          in_item,
    input  logic [QLVL_W-1:0] q_level,
    output logic              job_push,
    output job_t              job_data
);

    logic                     s1_valid_reg;
    logic                     s1_last_reg;
    logic signed [PROD_W-1:0] p_ab_reg, p_aa_reg, p_bb_reg, p_dd_reg;
    logic signed [ACC_W-1:0]  dot_reg, na_reg, nb_reg, dsq_reg;
    logic signed [ACC_W-1:0]  dot_next, na_next, nb_next, dsq_next;
    logic signed [ELEM_W:0]   diff;
    logic signed [2*ELEM_W+1:0] dd_full;
    logic [QLVL_W:0]          in_flight;
    logic                     accept;

    // Count vectors queued or being handed over to the queue
    assign in_flight = {1'b0, q_level} + {{QLVL_W{1'b0}}, s1_valid_reg & s1_last_reg};
    assign full      = (in_flight >= (QLVL_W+1)'(QDEPTH));
    assign accept    = push & ~full;

    assign diff    = {in_item.elem_a[ELEM_W-1], in_item.elem_a}
                   - {in_item.elem_b[ELEM_W-1], in_item.elem_b};
    assign dd_full = diff * diff;

    // Register products
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_last_reg <= in_item.last_elem;
            p_ab_reg    <= PROD_W'(in_item.elem_a * in_item.elem_b);
            p_aa_reg    <= PROD_W'(in_item.elem_a * in_item.elem_a);
            p_bb_reg    <= PROD_W'(in_item.elem_b * in_item.elem_b);
            p_dd_reg    <= {2'b00, dd_full[2*ELEM_W-1:0]};
        end
    end

    // Accumulate with saturation
    always_comb
    begin
        dot_next = sat_add(dot_reg, p_ab_reg);
        na_next  = sat_add(na_reg,  p_aa_reg);
        nb_next  = sat_add(nb_reg,  p_bb_reg);
        dsq_next = sat_add(dsq_reg, p_dd_reg);
    end

    assign job_push         = s1_valid_reg & s1_last_reg;
    assign job_data.dot     = dot_next;
    assign job_data.norm_a  = na_next;
    assign job_data.norm_b  = nb_next;
    assign job_data.diff_sq = dsq_next;

    // Clear the sums once a vector is handed over
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_reg <= '0;
            na_reg  <= '0;
            nb_reg  <= '0;
            dsq_reg <= '0;
        end
        else if (s1_valid_reg)
        begin
            if (s1_last_reg)
            begin
                dot_reg <= '0;
                na_reg  <= '0;
                nb_reg  <= '0;
                dsq_reg <= '0;
            end
            else
            begin
                dot_reg <= dot_next;
                na_reg  <= na_next;
                nb_reg  <= nb_next;
                dsq_reg <= dsq_next;
            end
        end
    end

endmodule

### hw/rtl/vss_fifo.sv
// Job queue: holds finished vector sums between front and back.
module vss_fifo
    import vss_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  job_t              wr_data,
    input  logic              rd_en,
    output job_t              rd_data,
    output logic              q_empty,
    output logic [QLVL_W-1:0] level
);

    job_t              slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QLVL_W-1:0] level_reg;

    assign rd_data = slot_reg[rd_ptr_reg];
    assign q_empty = (level_reg == '0);
    assign level   = level_reg;

    // Store item
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // Advance pointers and level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (rd_en)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            level_reg <= level_reg + QLVL_W'(wr_en) - QLVL_W'(rd_en);
        end
    end

endmodule

### hw/rtl/vss_back.sv
// Back end: roots, divide and scoring of one vector pair at a time.
module vss_back
    import vss_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic [1:0] mode,
    input  logic      q_empty,
    input  job_t      q_head,
    output logic      q_pop,
    output logic      empty,
    input  logic      pop,
    output out_item_t out_item
);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_SQA  = 7'b0000010,
        ST_SQB  = 7'b0000100,
        ST_SQE  = 7'b0001000,
        ST_MUL  = 7'b0010000,
        ST_DIV  = 7'b0100000,
        ST_FIN  = 7'b1000000
    } state_t;

    state_t      state_reg, state_next;
    logic [6:0]  cnt_reg, cnt_next;

    // Square root datapath
    logic [63:0] x_reg, x_next;
    logic [34:0] rem_reg, rem_next;
    logic [31:0] root_reg, root_next;
    logic [34:0] rem2, trial;
    logic        sq_ge;

    // Divide datapath
    logic [31:0] ra_reg, ra_next, rb_reg, rb_next;
    logic [63:0] den_reg, den_next;
    logic [79:0] num_reg, num_next;
    logic [64:0] r_reg, r_next, r2;
    logic [47:0] q_reg, q_next;
    logic        ovf_reg, ovf_next, dv_ge;
    logic        neg_reg, neg_next;

    logic signed [ACC_W-1:0] res_reg, res_next;
    logic        flag_reg, flag_next;
    logic        out_valid_reg, out_valid_next;
    out_item_t   out_reg, out_next;

    logic        head_neg, is_cos;
    logic [47:0] head_mag;

    assign head_neg = q_head.dot[ACC_W-1];
    assign head_mag = head_neg ? 48'(-q_head.dot) : 48'(q_head.dot);
    assign is_cos   = (mode == MODE_COS) || (mode == MODE_RSV);

    // One root step: two radicand bits per cycle
    assign rem2  = {rem_reg[32:0], x_reg[63:62]};
    assign trial = {1'b0, root_reg, 2'b01};
    assign sq_ge = (rem2 >= trial);

    // One quotient bit per cycle
    assign r2    = {r_reg[63:0], num_reg[79]};
    assign dv_ge = (r2 >= {1'b0, den_reg});

    assign q_pop    = (state_reg == ST_IDLE) && !q_empty;
    assign empty    = !out_valid_reg;
    assign out_item = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        x_next         = x_reg;
        rem_next       = rem_reg;
        root_next      = root_reg;
        ra_next        = ra_reg;
        rb_next        = rb_reg;
        den_next       = den_reg;
        num_next       = num_reg;
        r_next         = r_reg;
        q_next         = q_reg;
        ovf_next       = ovf_reg;
        neg_next       = neg_reg;
        res_next       = res_reg;
        flag_next      = flag_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !pop;

        unique case (state_reg)
            ST_IDLE:
            begin
                // Pick up the next job and classify it
                if (!q_empty)
                begin
                    rem_next  = '0;
                    root_next = '0;
                    cnt_next  = 7'd31;
                    neg_next  = head_neg;
                    num_next  = {head_mag, 32'd0};
                    rb_next   = q_head.norm_b[47:16];
                    x_next    = {q_head.norm_b[47:0], 16'd0};
                    flag_next = 1'b0;
                    if (mode == MODE_EUC)
                    begin
                        x_next     = {8'd0, q_head.diff_sq, 8'd0};
                        state_next = ST_SQE;
                    end
                    else if (mode == MODE_IP)
                    begin
                        res_next   = head_neg ? -$signed(head_mag >> 8)
                                              : $signed(head_mag >> 8);
                        state_next = ST_FIN;
                    end
                    else if (is_cos && (q_head.norm_a == '0 || q_head.norm_b == '0))
                    begin
                        res_next   = '0;
                        flag_next  = 1'b1;
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        x_next     = {q_head.norm_a[47:0], 16'd0};
                        // Park norm_b radicand in den until root a is done
                        den_next   = {q_head.norm_b[47:0], 16'd0};
                        state_next = ST_SQA;
                    end
                end
            end
            ST_SQA, ST_SQB, ST_SQE:
            begin
                rem_next  = sq_ge ? (rem2 - trial) : rem2;
                root_next = {root_reg[30:0], sq_ge};
                x_next    = {x_reg[61:0], 2'b00};
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    if (state_reg == ST_SQA)
                    begin
                        ra_next    = {root_reg[30:0], sq_ge};
                        x_next     = den_reg;
                        rem_next   = '0;
                        root_next  = '0;
                        cnt_next   = 7'd31;
                        state_next = ST_SQB;
                    end
                    else if (state_reg == ST_SQB)
                    begin
                        rb_next    = {root_reg[30:0], sq_ge};
                        state_next = ST_MUL;
                    end
                    else
                    begin
                        res_next   = -$signed({16'd0, root_reg[30:0], sq_ge});
                        state_next = ST_FIN;
                    end
                end
            end
            ST_MUL:
            begin
                den_next   = ra_reg * rb_reg;
                r_next     = '0;
                q_next     = '0;
                ovf_next   = 1'b0;
                cnt_next   = 7'd79;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                r_next   = dv_ge ? (r2 - {1'b0, den_reg}) : r2;
                q_next   = {q_reg[46:0], dv_ge};
                ovf_next = ovf_reg | q_reg[47];
                num_next = {num_reg[78:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    // Saturate to the score range
                    if (ovf_reg || q_reg[47] || q_reg[46])
                        res_next = neg_reg ? ACC_MIN : ACC_MAX;
                    else
                        res_next = neg_reg ? -$signed({q_reg[46:0], dv_ge})
                                           : $signed({q_reg[46:0], dv_ge});
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                // Hand over once the output slot is free
                if (!out_valid_reg || pop)
                begin
                    out_next.score     = res_reg;
                    out_next.zero_norm = flag_reg;
                    out_valid_next     = 1'b1;
                    state_next         = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        x_reg    <= x_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        ra_reg   <= ra_next;
        rb_reg   <= rb_next;
        den_reg  <= den_next;
        num_reg  <= num_next;
        r_reg    <= r_next;
        q_reg    <= q_next;
        ovf_reg  <= ovf_next;
        neg_reg  <= neg_next;
        res_reg  <= res_next;
        flag_reg <= flag_next;
        out_reg  <= out_next;
    end

endmodule

### hw/rtl/vector_similarity_score_core.sv
// Top level: vector similarity score core with job queue between front and back.
//
//  channel   direction  handshake           payload
//  input     in         push / full         in_item  (elem_a, elem_b, last_elem)
//  result    out        pop / empty         out_item (score, zero_norm)
//  config    in         cfg_we              cfg_data (metric_mode)
//
// The front takes one element pair per cycle while full is low; the registered products
// enter the sums in the cycle after acceptance. Each vector closed by last_elem queues
// up to 4 deep for the back end: cosine runs the 2-bit-per-cycle root unit and the
// 1-bit-per-cycle divider, euclidean the root alone, inner product or zero norm neither.
// full rises only while 4 closed vectors wait; one finished result is held until popped.
// Reset clears sums, queue, mode and the result slot.
module vector_similarity_score_core
    import vss_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  in_item_t   in_item,
    output logic       empty,
    input  logic       pop,
    output out_item_t  out_item,
    input  logic       cfg_we,
    input  logic [1:0] cfg_data
);

    logic [1:0]        mode_reg;
    logic              job_push, q_pop, q_empty;
    job_t              job_data, q_head;
    logic [QLVL_W-1:0] q_level;

    // Hold the metric mode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= MODE_COS;
        else if (cfg_we)
            mode_reg <= cfg_data;
    end

    vss_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .in_item  (in_item),
        .q_level  (q_level),
        .job_push (job_push),
        .job_data (job_data)
    );

    vss_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_push),
        .wr_data (job_data),
        .rd_en   (q_pop),
        .rd_data (q_head),
        .q_empty (q_empty),
        .level   (q_level)
    );

    vss_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .mode     (mode_reg),
        .q_empty  (q_empty),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .empty    (empty),
        .pop      (pop),
        .out_item (out_item)
    );

endmodule

### test/tb_top.sv
// Testbench: vector similarity score core checked against a built-in score predictor.
`timescale 1ns / 100ps

class score_board;
    logic signed [47:0] dot_acc;
    logic signed [47:0] norm_a_acc;
    logic signed [47:0] norm_b_acc;
    logic signed [47:0] dist_acc;
    logic [1:0]         mode;
    vss_pkg::out_item_t pending_scores[$];
    int                 err_count;

    function new();
        dot_acc = 0;
        norm_a_acc = 0;
        norm_b_acc = 0;
        dist_acc = 0;
        mode = vss_pkg::MODE_COS;
        err_count = 0;
    endfunction

    // Saturate a sum into the 48-bit range
    function logic signed [47:0] sat48(longint s);
        if (s > 64'sh7FFF_FFFF_FFFF)
            return vss_pkg::ACC_MAX;
        if (s < -64'sh8000_0000_0000)
            return vss_pkg::ACC_MIN;
        return s[47:0];
    endfunction

    function longint unsigned root64(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b >>= 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function longint cos_ratio();
        longint unsigned ra;
        longint unsigned rb;
        longint unsigned den;
        longint unsigned mag;
        longint unsigned q;
        longint unsigned r;
        longint          d;
        bit              neg;
        ra = root64(longint'(norm_a_acc) << 16);
        rb = root64(longint'(norm_b_acc) << 16);
        den = ra * rb;
        d = dot_acc;
        neg = d < 0;
        mag = neg ? -d : d;
        if (den == 0)
            return 0;
        q = mag / den;
        r = mag % den;
        if (q >= (64'd1 << 15))
            return neg ? longint'(vss_pkg::ACC_MIN) : longint'(vss_pkg::ACC_MAX);
        for (int i = 0; i < 32; i++)
        begin
            r <<= 1;
            q <<= 1;
            if (r >= den)
            begin
                r -= den;
                q |= 1;
            end
        end
        if (neg)
            return (q > 64'h8000_0000_0000) ? longint'(vss_pkg::ACC_MIN) : -longint'(q);
        return (q > 64'h7FFF_FFFF_FFFF) ? longint'(vss_pkg::ACC_MAX) : longint'(q);
    endfunction

    // Accumulate one accepted item; queue a score on the last pair
    function void note_pair(vss_pkg::in_item_t it);
        longint a;
        longint b;
        longint d;
        longint s;
        vss_pkg::out_item_t exp_item;
        a = it.elem_a;
        b = it.elem_b;
        d = a - b;
        dot_acc = sat48(longint'(dot_acc) + a * b);
        norm_a_acc = sat48(longint'(norm_a_acc) + a * a);
        norm_b_acc = sat48(longint'(norm_b_acc) + b * b);
        dist_acc = sat48(longint'(dist_acc) + d * d);
        if (!it.last_elem)
            return;
        exp_item.zero_norm = 1'b0;
        if (mode == vss_pkg::MODE_EUC)
            s = -longint'(root64(longint'(dist_acc) << 8));
        else if (mode == vss_pkg::MODE_IP)
            s = (dot_acc < 0) ? -((-longint'(dot_acc)) >>> 8) : (longint'(dot_acc) >>> 8);
        else if (norm_a_acc == 0 || norm_b_acc == 0)
        begin
            s = 0;
            exp_item.zero_norm = 1'b1;
        end
        else
            s = cos_ratio();
        exp_item.score = s[47:0];
        pending_scores.push_back(exp_item);
        dot_acc = 0;
        norm_a_acc = 0;
        norm_b_acc = 0;
        dist_acc = 0;
    endfunction

    // Compare one popped result with the oldest expected score
    function void check_score(vss_pkg::out_item_t got);
        vss_pkg::out_item_t want;
        if (pending_scores.size() == 0)
        begin
            $display("%0t: unexpected result score=%h zero_norm=%b", $time, got.score,
                     got.zero_norm);
            err_count++;
            return;
        end
        want = pending_scores.pop_front();
        if (got.score !== want.score)
        begin
            $display("%0t: score mismatch expected %h actual %h", $time, want.score,
                     got.score);
            err_count++;
        end
        if (got.zero_norm !== want.zero_norm)
        begin
            $display("%0t: zero_norm mismatch expected %b actual %b", $time,
                     want.zero_norm, got.zero_norm);
            err_count++;
        end
    endfunction
endclass

module tb_top;
    import vss_pkg::*;

    logic       clk;
    logic       rst_n;
    logic       push;
    logic       full;
    in_item_t   in_item;
    logic       empty;
    logic       pop;
    out_item_t  out_item;
    logic       cfg_we;
    logic [1:0] cfg_data;

    score_board sb;
    int         push_idle_pct;
    int         pop_idle_pct;
    bit         hold_pop;

    vector_similarity_score_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .in_item  (in_item),
        .empty    (empty),
        .pop      (pop),
        .out_item (out_item),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    always #5 clk = ~clk;

    // Drive pop at random; check each accepted result
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            sb.check_score(out_item);
        pop <= !hold_pop && ($urandom_range(99) >= pop_idle_pct);
    end

    // Offer one item, with random gaps, until accepted
    task automatic send_pair(logic signed [15:0] a, logic signed [15:0] b, logic last);
        in_item_t it;
        it.elem_a = a;
        it.elem_b = b;
        it.last_elem = last;
        while ($urandom_range(99) < push_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sb.note_pair(it);
    endtask

    function automatic logic signed [15:0] rand_elem();
        case ($urandom_range(5))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'sh0000;
            3: return 16'($urandom_range(511) - 256);
            default: return 16'($urandom);
        endcase
    endfunction

    // Wait for all scores, let the back end settle, then set the mode
    task automatic set_mode(logic [1:0] m);
        push <= 1'b0;
        while (sb.pending_scores.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= m;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.mode = m;
    endtask

    // Send one random vector; mostly short, a few long ones
    task automatic send_vector();
        int len;
        len = ($urandom_range(19) == 0) ? $urandom_range(300, 60) : $urandom_range(1, 8);
        for (int i = 1; i <= len; i++)
            send_pair(rand_elem(), rand_elem(), i == len);
    endtask

    initial
    begin
        logic [1:0] modes[4];
        modes = '{MODE_EUC, MODE_IP, MODE_RSV, MODE_COS};
        sb = new();
        clk = 1'b0;
        rst_n = 1'b0;
        push = 1'b0;
        in_item = '0;
        pop = 1'b0;
        cfg_we = 1'b0;
        cfg_data = MODE_COS;
        hold_pop = 1'b0;
        push_idle_pct = 15;
        pop_idle_pct = 66;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, zero norms, every mode
        for (int m = 0; m < 4; m++)
        begin
            set_mode(modes[(m + 3) % 4]);
            send_pair(16'sh7FFF, 16'sh8000, 1'b1);
            send_pair(16'sh0000, 16'sh1000, 1'b1);
            send_pair(16'sh1000, 16'sh0000, 1'b1);
            send_pair(16'sh8000, 16'sh8000, 1'b0);
            send_pair(16'sh8000, 16'sh8000, 1'b1);
            send_pair(16'sh0001, 16'shFFFF, 1'b1);
        end

        // Fill the queue while results are held back for a long stretch
        set_mode(MODE_COS);
        hold_pop = 1'b1;
        fork
            begin
                repeat (1500) @(posedge clk);
                hold_pop = 1'b0;
            end
            for (int i = 0; i < 12; i++)
                send_pair(rand_elem(), rand_elem(), 1'b1);
        join

        // Random vectors across three idling phases and all modes
        for (int ph = 0; ph < 3; ph++)
        begin
            push_idle_pct = (ph == 0) ? 15 : (ph == 1) ? 66 : 0;
            pop_idle_pct = (ph == 0) ? 66 : (ph == 1) ? 15 : 0;
            for (int k = 0; k < 4; k++)
            begin
                set_mode(modes[(ph + k) % 4]);
                for (int v = 0; v < 4; v++)
                    send_vector();
            end
        end
        push <= 1'b0;
        while (sb.pending_scores.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (sb.err_count == 0)
            $display("** vector_similarity_score_core: PASSED **");
        else
            $display("** vector_similarity_score_core: FAILED **");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("** vector_similarity_score_core: FAILED **");
        $finish;
    end
endmodule

### filelist.f
hw/rtl/vss_pkg.sv
hw/rtl/vss_front.sv
hw/rtl/vss_fifo.sv
hw/rtl/vss_back.sv
hw/rtl/vector_similarity_score_core.sv
test/tb_top.sv
